// File: hw/rtl/smx_pkg.sv
// smx_pkg: opcodes, fault codes, sizes and state types for the stack machine execute unit.
// No dependencies.
`default_nettype none
package smx_pkg;
    localparam int MEM_WORDS  = 32768;
    localparam int CODE_WORDS = 32768;
    localparam int WA_W = $clog2(MEM_WORDS);
    localparam int BA_W = WA_W + 3;
    localparam int PC_W = $clog2(CODE_WORDS);

    localparam logic [7:0] OP_IMM  = 8'd100;
    localparam logic [7:0] OP_LEA  = 8'd101;
    localparam logic [7:0] OP_LC   = 8'd102;
    localparam logic [7:0] OP_LI   = 8'd103;
    localparam logic [7:0] OP_SC   = 8'd104;
    localparam logic [7:0] OP_SI   = 8'd105;
    localparam logic [7:0] OP_PUSH = 8'd106;
    localparam logic [7:0] OP_ADD  = 8'd107;
    localparam logic [7:0] OP_SUB  = 8'd108;
    localparam logic [7:0] OP_MUL  = 8'd109;
    localparam logic [7:0] OP_DIV  = 8'd110;
    localparam logic [7:0] OP_MOD  = 8'd111;
    localparam logic [7:0] OP_OR   = 8'd112;
    localparam logic [7:0] OP_XOR  = 8'd113;
    localparam logic [7:0] OP_AND  = 8'd114;
    localparam logic [7:0] OP_SHL  = 8'd115;
    localparam logic [7:0] OP_SHR  = 8'd116;
    localparam logic [7:0] OP_EQ   = 8'd117;
    localparam logic [7:0] OP_NE   = 8'd118;
    localparam logic [7:0] OP_LT   = 8'd119;
    localparam logic [7:0] OP_LE   = 8'd120;
    localparam logic [7:0] OP_GT   = 8'd121;
    localparam logic [7:0] OP_GE   = 8'd122;
    localparam logic [7:0] OP_JMP  = 8'd123;
    localparam logic [7:0] OP_JZ   = 8'd124;
    localparam logic [7:0] OP_JNZ  = 8'd125;

    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_DIV0  = 2'd1;
    localparam logic [1:0] FAULT_UNSUP = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD0, ST_RD1, ST_EXEC, ST_APPLY, ST_MUL, ST_DIV,
        ST_WR0, ST_WR1, ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic [63:0] num;
        logic [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic [63:0] quo;
        logic [63:0] rem;
    } div_rsp_t;
endpackage
`default_nettype wire

// File: hw/rtl/smx_divider.sv
// smx_divider: signed 64-bit restoring divider, one quotient bit per cycle.
// Depends on smx_pkg.
`default_nettype none
module smx_divider
    import smx_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);
    logic        busy_reg, busy_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] q_reg, q_next, r_reg, r_next, d_reg, d_next;
    logic        nq_reg, nq_next, nr_reg, nr_next;
    logic [64:0] trial;
    logic [63:0] rs;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next = q_reg; r_next = r_reg; d_next = d_reg;
        nq_next = nq_reg; nr_next = nr_reg;
        rs    = {r_reg[62:0], q_reg[63]};
        trial = {1'b0, rs} - {1'b0, d_reg};
        rsp.done = 1'b0;
        rsp.quo  = nq_reg ? (64'd0 - q_reg) : q_reg;
        rsp.rem  = nr_reg ? (64'd0 - r_reg) : r_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 7'd0;
            q_next = req.num[63] ? (64'd0 - req.num) : req.num;
            d_next = req.den[63] ? (64'd0 - req.den) : req.den;
            r_next = '0;
            nq_next = req.num[63] ^ req.den[63];
            nr_next = req.num[63];
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 7'd64)
            begin
                busy_next = 1'b0;
                rsp.done  = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 7'd1;
                if (!trial[64])
                begin
                    r_next = trial[63:0];
                    q_next = {q_reg[62:0], 1'b1};
                end
                else
                begin
                    r_next = rs;
                    q_next = {q_reg[62:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next; r_reg <= r_next; d_reg <= d_next;
        nq_reg <= nq_next; nr_reg <= nr_next;
    end
endmodule
`default_nettype wire

// File: hw/rtl/stack_machine_execute_unit.sv
// stack_machine_execute_unit: top level of the accumulator/stack machine execute unit.
// Depends on smx_pkg and smx_divider.
//
// Executes one instruction per accepted input word and returns one output word
// (next_pc, accumulator_value, fault_code). Data lives in a 32768 x 64-bit
// synchronous RAM with a registered read, addressed by byte; every memory
// access reads both rows a word at that byte address can touch, so unaligned
// words take the same path as aligned ones. Unsupported opcodes go straight
// to the output; IMM, LEA and jumps need no memory access; loads, pop-based
// ALU ops and a divide or modulo by zero read two rows first; PUSH reads,
// merges and writes; MUL sums three 32x32 partial products; SC/SI pop, then
// read-merge-write at the target; DIV/MOD run in the bit-serial divider. The
// RAM serves one read at a time, and with the two-row read this paces memory
// opcodes. One instruction is in flight at a time and all writes finish
// before it reports. The output word sits in a register: the next input is
// taken while it waits, and the unit only stalls once a second word is ready.
// Unwritten memory reads back undefined data.
`default_nettype none
module stack_machine_execute_unit
    import smx_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [7:0]          kind,
    input  wire logic signed [63:0]  operand_word,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [PC_W-1:0]          next_pc,
    output logic signed [63:0]       accumulator_value,
    output logic [1:0]               fault_code
);
    // data RAM
    logic [63:0] mem [MEM_WORDS];
    logic        we;
    logic [WA_W-1:0] waddr, raddr;
    logic [63:0] wdata, rdata;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

    // architectural state
    logic [63:0]     acc_reg, acc_next;
    logic [BA_W-1:0] sp_reg, sp_next, fp_reg;
    logic [PC_W-1:0] pc_reg, pc_next;
    state_t          st_reg, st_next;

    // per-instruction working registers
    logic [7:0]      op_reg, op_next;
    logic [63:0]     w_reg, w_next;
    logic [BA_W-1:0] ad_reg, ad_next;      // byte address of the access
    logic [63:0]     lo_reg, lo_next;      // first row read
    logic [63:0]     l_reg, l_next;        // assembled loaded word
    logic [63:0]     prod_reg, prod_next;
    logic [63:0]     r1_reg, r1_next;      // second row read
    logic [PC_W-1:0] npc_reg, npc_next;
    logic [1:0]      flt_reg, flt_next;
    logic            pass_reg, pass_next;  // store: rows now read at the target
    logic [1:0]      mc_reg, mc_next;      // partial product step
    logic            ov_reg, ov_next;
    logic [PC_W-1:0] opc_reg, opc_next;
    logic [63:0]     oacc_reg, oacc_next;
    logic [1:0]      oflt_reg, oflt_next;

    div_req_t dreq;
    div_rsp_t drsp;

    smx_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic [2:0]      boff;
    logic [WA_W-1:0] row0, row1;
    logic [127:0]    pair, pair_w, mask;
    logic [63:0]     wval, res;
    logic [5:0]      sh;
    logic            slt, sgt;
    logic [PC_W-1:0] pc1, pc2, tgt;
    logic            is_word;
    logic [31:0]     mul_a, mul_b;
    logic [63:0]     mul_p, prod_sum;

    assign boff = ad_reg[2:0];
    assign row0 = ad_reg[BA_W-1:3];
    assign row1 = row0 + 1'b1;
    assign pc1  = pc_reg + 1'b1;
    assign pc2  = pc_reg + 2'd2;
    assign tgt  = w_reg[PC_W-1:0];
    assign sh   = acc_reg[5:0];
    assign slt  = $signed(l_reg) < $signed(acc_reg);
    assign sgt  = $signed(l_reg) > $signed(acc_reg);
    assign is_word = (op_reg != OP_SC);

    // low 64 bits of l * acc: lo*lo, then lo*hi and hi*lo shifted up 32
    assign mul_a    = (mc_reg == 2'd2) ? l_reg[63:32] : l_reg[31:0];
    assign mul_b    = (mc_reg == 2'd1) ? acc_reg[63:32] : acc_reg[31:0];
    assign mul_p    = mul_a * mul_b;
    assign prod_sum = prod_reg + {mul_p[31:0], 32'd0};

    // read-modify-write merge for stores: value is placed at the byte offset
    assign wval   = acc_reg;
    assign mask   = (is_word ? {64'd0, 64'hFFFF_FFFF_FFFF_FFFF} : 128'hFF) << {boff, 3'b000};
    assign pair   = {r1_reg, lo_reg};
    assign pair_w = (pair & ~mask) | (({64'd0, wval} << {boff, 3'b000}) & mask);

    always_comb
    begin
        unique case (op_reg)
            OP_ADD:  res = l_reg + acc_reg;
            OP_SUB:  res = l_reg - acc_reg;
            OP_OR:   res = l_reg | acc_reg;
            OP_XOR:  res = l_reg ^ acc_reg;
            OP_AND:  res = l_reg & acc_reg;
            OP_SHL:  res = l_reg << sh;
            OP_SHR:  res = $unsigned($signed(l_reg) >>> sh);
            OP_EQ:   res = {63'd0, l_reg == acc_reg};
            OP_NE:   res = {63'd0, l_reg != acc_reg};
            OP_LT:   res = {63'd0, slt};
            OP_LE:   res = {63'd0, !sgt};
            OP_GT:   res = {63'd0, sgt};
            OP_GE:   res = {63'd0, !slt};
            default: res = acc_reg;
        endcase
    end

    assign in_stall          = (st_reg != ST_IDLE);
    assign out_valid         = ov_reg;
    assign next_pc           = opc_reg;
    assign accumulator_value = oacc_reg;
    assign fault_code        = oflt_reg;

    always_comb
    begin
        st_next = st_reg;
        acc_next = acc_reg; sp_next = sp_reg; pc_next = pc_reg;
        op_next = op_reg; w_next = w_reg; ad_next = ad_reg;
        lo_next = lo_reg; l_next = l_reg; prod_next = prod_reg; r1_next = r1_reg;
        npc_next = npc_reg; flt_next = flt_reg;
        pass_next = pass_reg; mc_next = mc_reg;
        ov_next = ov_reg && out_stall;
        opc_next = opc_reg; oacc_next = oacc_reg; oflt_next = oflt_reg;
        we = 1'b0; waddr = row0; wdata = pair_w[63:0]; raddr = row0;
        dreq.start = 1'b0;
        dreq.num = l_reg; dreq.den = acc_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next = kind;
                    w_next  = operand_word;
                    flt_next = FAULT_NONE;
                    npc_next = pc1;
                    pass_next = 1'b0;
                    priority if (kind < OP_IMM || kind > OP_JNZ)
                        st_next = ST_OUT;
                    else if (kind == OP_LC || kind == OP_LI)
                    begin
                        ad_next = acc_reg[BA_W-1:0];
                        st_next = ST_RD0;
                    end
                    else if (kind == OP_PUSH)
                    begin
                        ad_next = sp_reg - 4'd8;
                        sp_next = sp_reg - 4'd8;
                        st_next = ST_RD0;
                    end
                    else if (kind >= OP_SC && kind <= OP_GE)
                    begin
                        ad_next = sp_reg;
                        sp_next = sp_reg + 4'd8;
                        st_next = ST_RD0;
                    end
                    else
                        st_next = ST_EXEC;
                end
            end
            ST_RD0:
            begin
                raddr = row0;   // data arrives next cycle
                st_next = ST_RD1;
            end
            ST_RD1:
            begin
                // rdata holds row0; fetch row1 in case the word spans it
                lo_next = rdata;
                raddr = row1;
                st_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                // rdata holds row1 for memory opcodes
                r1_next = rdata;
                l_next  = 64'({rdata, lo_reg} >> {boff, 3'b000});
                st_next = ST_OUT;
                priority if (op_reg == OP_IMM)
                begin
                    acc_next = w_reg; npc_next = pc2;
                end
                else if (op_reg == OP_LEA)
                begin
                    acc_next = {{(64-BA_W){1'b0}}, fp_reg + {w_reg[BA_W-4:0], 3'b000}};
                    npc_next = pc2;
                end
                else if (op_reg == OP_JMP)
                    npc_next = tgt;
                else if (op_reg == OP_JZ)
                    npc_next = (acc_reg != 0) ? pc2 : tgt;
                else if (op_reg == OP_JNZ)
                    npc_next = (acc_reg != 0) ? tgt : pc2;
                else if (op_reg == OP_PUSH || pass_reg)
                    st_next = ST_WR0;   // rows in hand, merge and write
                else
                    st_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                priority if (op_reg == OP_LC)
                begin
                    acc_next = {{56{l_reg[7]}}, l_reg[7:0]};
                    st_next = ST_OUT;
                end
                else if (op_reg == OP_LI)
                begin
                    acc_next = l_reg;
                    st_next = ST_OUT;
                end
                else if (op_reg == OP_SC || op_reg == OP_SI)
                begin
                    // popped address known: read the target rows
                    ad_next = l_reg[BA_W-1:0];
                    pass_next = 1'b1;
                    st_next = ST_RD0;
                end
                else if (op_reg == OP_MUL)
                begin
                    mc_next = 2'd0;
                    st_next = ST_MUL;
                end
                else if (op_reg == OP_DIV || op_reg == OP_MOD)
                begin
                    if (acc_reg == 64'd0)
                    begin
                        acc_next = '0; flt_next = FAULT_DIV0; st_next = ST_OUT;
                    end
                    else
                    begin
                        dreq.start = 1'b1; st_next = ST_DIV;
                    end
                end
                else
                begin
                    acc_next = res;
                    st_next = ST_OUT;
                end
            end
            ST_MUL:
            begin
                mc_next = mc_reg + 2'd1;
                if (mc_reg == 2'd0)
                    prod_next = mul_p;
                else
                    prod_next = prod_sum;
                if (mc_reg == 2'd2)
                begin
                    acc_next = prod_sum;
                    st_next = ST_OUT;
                end
            end
            ST_DIV:
            begin
                if (drsp.done)
                begin
                    acc_next = (op_reg == OP_MOD) ? drsp.rem : drsp.quo;
                    st_next = ST_OUT;
                end
            end
            ST_WR0:
            begin
                we = 1'b1; waddr = row0; wdata = pair_w[63:0];
                st_next = ST_WR1;
            end
            ST_WR1:
            begin
                if (boff != 3'd0)
                begin
                    we = 1'b1; waddr = row1; wdata = pair_w[127:64];
                end
                st_next = ST_OUT;
            end
            ST_OUT:
            begin
                // wait here while the previous word is still held
                if (!ov_reg || !out_stall)
                begin
                    if (op_reg < OP_IMM || op_reg > OP_JNZ)
                    begin
                        opc_next = pc_reg; oacc_next = acc_reg; oflt_next = FAULT_UNSUP;
                    end
                    else
                    begin
                        pc_next = npc_reg;
                        opc_next = npc_reg; oacc_next = acc_reg; oflt_next = flt_reg;
                    end
                    ov_next = 1'b1;
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_IDLE;
            acc_reg <= '0;
            sp_reg  <= '0;
            fp_reg  <= '0;
            pc_reg  <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            acc_reg <= acc_next;
            sp_reg  <= sp_next;
            pc_reg  <= pc_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next; w_reg <= w_next; ad_reg <= ad_next;
        lo_reg <= lo_next; l_reg <= l_next; prod_reg <= prod_next; r1_reg <= r1_next;
        npc_reg <= npc_next; flt_reg <= flt_next;
        pass_reg <= pass_next; mc_reg <= mc_next;
        opc_reg <= opc_next; oacc_reg <= oacc_next; oflt_reg <= oflt_next;
    end
endmodule
`default_nettype wire

// File: hw/rtl/smx_checker.sv
// smx_checker: port-level assertions for stack_machine_execute_unit, bound to the top.
// Depends on smx_pkg.
`default_nettype none
module smx_checker
    import smx_pkg::*;
(
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            in_valid,
    input wire logic            in_stall,
    input wire logic            out_valid,
    input wire logic            out_stall,
    input wire logic [PC_W-1:0] next_pc,
    input wire logic [1:0]      fault_code
);
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(next_pc))
        else $error("output word dropped under stall");
    a_fault_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> fault_code != 2'd3)
        else $error("bad fault code");
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second word taken while busy");
    a_fault_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(fault_code))
        else $error("fault code changed under stall");
endmodule

bind stack_machine_execute_unit smx_checker u_smx_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .next_pc(next_pc),
    .fault_code(fault_code)
);
`default_nettype wire
